>>> rtl/rgbhsv_pkg.sv
// shared types, constants and the divider step for the rgb to hsv converter
package rgbhsv_pkg;

    localparam int SAT_FRAC_BITS_DEF = 16;

    localparam int CHAN_W   = 8;
    localparam int HUE_W    = 9;
    localparam int SAT_W    = 17;
    localparam int HUE_NUM_W = 14;
    localparam int HUE_Q_W  = 6;

    localparam logic [HUE_W-1:0] HUE_RED   = 9'd0;
    localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_NUM_W-1:0] HUE_SCALE = 14'd60;
    localparam logic [SAT_W-1:0] SAT_MAX   = 17'h1FFFF;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_deg;
        logic [SAT_W-1:0]  saturation_frac;
        logic [CHAN_W-1:0] value_level;
    } t_hsv;

    typedef struct packed {
        logic              q;
        logic [CHAN_W-1:0] rem;
    } t_div_step;

    // one restoring step: shift in a dividend bit, subtract the divisor if it fits
    function automatic t_div_step div_step(input logic [CHAN_W-1:0] rem,
                                           input logic              din,
                                           input logic [CHAN_W-1:0] dvsr);
        logic [CHAN_W:0] trial;
        logic [CHAN_W:0] diff;
        t_div_step       res;
        trial = {rem, din};
        diff  = trial - {1'b0, dvsr};
        if (trial >= {1'b0, dvsr}) begin
            res.q   = 1'b1;
            res.rem = diff[CHAN_W-1:0];
        end else begin
            res.q   = 1'b0;
            res.rem = trial[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/rgb_to_hsv_convert_core.sv
// rgb to hsv converter: input stage, setup stage, divider stages, output register
//
// Takes one rgb pixel per clock while o_stall is low and returns hue (whole degrees,
// floored), saturation (delta/max with SAT_FRAC_BITS fraction bits, truncated, clamped
// to 17 bits) and value. Sustained rate is one item per cycle while i_stall is low; the
// saturation divider resolves one quotient bit per pipeline stage, and the hue quotient
// (six bits) is resolved in the first six of those stages. Each stage moves whenever the
// stage after it is empty or moving, so bubbles close up under i_stall.
module rgb_to_hsv_convert_core #(
    parameter int SAT_FRAC_BITS = rgbhsv_pkg::SAT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rgbhsv_pkg::t_pixel i_pixel,
    output logic               o_valid,
    input  logic               i_stall,
    output rgbhsv_pkg::t_hsv   o_hsv
);
    import rgbhsv_pkg::*;

    localparam int QW   = SAT_FRAC_BITS + 1;
    localparam int NDIV = QW;
    localparam int WIDE = (QW > SAT_W) ? QW : SAT_W;

    // input stage
    logic   r_in_v;
    t_pixel r_in;
    logic   in_rdy;

    // setup stage
    logic                   r_pre_v;
    logic [CHAN_W-1:0]      r_pre_mx;
    logic [CHAN_W-1:0]      r_pre_dl;
    logic [HUE_NUM_W-1:0]   r_pre_hnum;
    logic [HUE_W-1:0]       r_pre_hbase;
    logic                   r_pre_hneg;
    logic                   pre_rdy;

    logic [CHAN_W-1:0]      n_mx;
    logic [CHAN_W-1:0]      n_mn;
    logic [CHAN_W-1:0]      n_dl;
    logic [CHAN_W-1:0]      n_pa;
    logic [CHAN_W-1:0]      n_pb;
    logic [CHAN_W-1:0]      n_mag;
    logic                   n_hneg;
    logic [HUE_W-1:0]       n_hbase;
    logic [HUE_NUM_W-1:0]   n_hnum;

    // divider stages
    logic                   r_dv_v    [NDIV];
    logic [CHAN_W-1:0]      r_dv_mx   [NDIV];
    logic [CHAN_W-1:0]      r_dv_dl   [NDIV];
    logic [CHAN_W-1:0]      r_dv_srem [NDIV];
    logic [QW-1:0]          r_dv_squo [NDIV];
    logic [HUE_NUM_W-1:0]   r_dv_hnum [NDIV];
    logic [CHAN_W-1:0]      r_dv_hrem [NDIV];
    logic [HUE_Q_W-1:0]     r_dv_hquo [NDIV];
    logic [HUE_W-1:0]       r_dv_hbase[NDIV];
    logic                   r_dv_hneg [NDIV];
    logic                   dv_rdy    [NDIV];

    // output register
    logic                   r_out_v;
    t_hsv                   r_out;
    logic                   out_rdy;
    t_hsv                   n_out;
    logic [WIDE-1:0]        n_sat_wide;

    // ready chain, back to front
    assign out_rdy = !r_out_v || !i_stall;
    assign dv_rdy[NDIV-1] = !r_dv_v[NDIV-1] || out_rdy;
    genvar k;
    generate
        for (k = 0; k < NDIV - 1; k++) begin : g_rdy
            assign dv_rdy[k] = !r_dv_v[k] || dv_rdy[k+1];
        end
    endgenerate
    assign pre_rdy = !r_pre_v || dv_rdy[0];
    assign in_rdy  = !r_in_v || pre_rdy;
    assign o_stall = !in_rdy;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_rdy) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy) begin
            r_in <= i_pixel;
        end
    end

    // setup: max, min, dominant channel and the hue dividend
    always_comb begin
        n_mx = r_in.red_in;
        n_mn = r_in.red_in;
        if (r_in.green_in > n_mx) n_mx = r_in.green_in;
        if (r_in.blue_in > n_mx)  n_mx = r_in.blue_in;
        if (r_in.green_in < n_mn) n_mn = r_in.green_in;
        if (r_in.blue_in < n_mn)  n_mn = r_in.blue_in;
        n_dl = n_mx - n_mn;

        if (n_mx == r_in.red_in) begin
            n_pa    = r_in.green_in;
            n_pb    = r_in.blue_in;
            n_hbase = HUE_RED;
        end else if (n_mx == r_in.green_in) begin
            n_pa    = r_in.blue_in;
            n_pb    = r_in.red_in;
            n_hbase = HUE_GREEN;
        end else begin
            n_pa    = r_in.red_in;
            n_pb    = r_in.green_in;
            n_hbase = HUE_BLUE;
        end

        n_hneg = n_pa < n_pb;
        n_mag  = n_hneg ? (n_pb - n_pa) : (n_pa - n_pb);
        n_hnum = HUE_NUM_W'(n_mag) * HUE_SCALE;
        // negative offset uses the ceiling, so round the dividend up
        if (n_hneg) begin
            n_hnum = n_hnum + HUE_NUM_W'(n_dl - 8'd1);
            if (n_hbase == HUE_RED) n_hbase = HUE_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= 1'b0;
        end else if (pre_rdy) begin
            r_pre_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_rdy) begin
            r_pre_mx    <= n_mx;
            r_pre_dl    <= n_dl;
            r_pre_hnum  <= n_hnum;
            r_pre_hbase <= n_hbase;
            r_pre_hneg  <= n_hneg;
        end
    end

    // one saturation quotient bit per stage, and one hue quotient bit in each of the first HUE_Q_W stages
    generate
        for (k = 0; k < NDIV; k++) begin : g_div
            logic                 src_v;
            logic [CHAN_W-1:0]    src_mx;
            logic [CHAN_W-1:0]    src_dl;
            logic [CHAN_W-1:0]    src_srem;
            logic [QW-1:0]        src_squo;
            logic [HUE_NUM_W-1:0] src_hnum;
            logic [CHAN_W-1:0]    src_hrem;
            logic [HUE_Q_W-1:0]   src_hquo;
            logic [HUE_W-1:0]     src_hbase;
            logic                 src_hneg;
            t_div_step            sstep;
            logic [CHAN_W-1:0]    n_hrem;
            logic [HUE_Q_W-1:0]   n_hquo;
            logic [QW-1:0]        n_squo;

            if (k == 0) begin : g_first
                // dividend bits above the quotient range seed the remainders
                assign src_v     = r_pre_v;
                assign src_mx    = r_pre_mx;
                assign src_dl    = r_pre_dl;
                assign src_srem  = {1'b0, r_pre_dl[CHAN_W-1:1]};
                assign src_squo  = '0;
                assign src_hnum  = r_pre_hnum;
                assign src_hrem  = r_pre_hnum[HUE_NUM_W-1:HUE_Q_W];
                assign src_hquo  = '0;
                assign src_hbase = r_pre_hbase;
                assign src_hneg  = r_pre_hneg;
            end else begin : g_next
                assign src_v     = r_dv_v[k-1];
                assign src_mx    = r_dv_mx[k-1];
                assign src_dl    = r_dv_dl[k-1];
                assign src_srem  = r_dv_srem[k-1];
                assign src_squo  = r_dv_squo[k-1];
                assign src_hnum  = r_dv_hnum[k-1];
                assign src_hrem  = r_dv_hrem[k-1];
                assign src_hquo  = r_dv_hquo[k-1];
                assign src_hbase = r_dv_hbase[k-1];
                assign src_hneg  = r_dv_hneg[k-1];
            end

            // saturation dividend is delta shifted up: only the first stage takes a dividend bit that can be nonzero
            if (k == 0) begin : g_sbit_d
                assign sstep = div_step(src_srem, src_dl[0], src_mx);
            end else begin : g_sbit_z
                assign sstep = div_step(src_srem, 1'b0, src_mx);
            end

            always_comb begin
                n_squo = src_squo;
                n_squo[QW-1-k] = sstep.q;
            end

            if (k < HUE_Q_W) begin : g_hue
                t_div_step hstep;
                assign hstep = div_step(src_hrem, src_hnum[HUE_Q_W-1-k], src_dl);
                always_comb begin
                    n_hrem = hstep.rem;
                    n_hquo = src_hquo;
                    n_hquo[HUE_Q_W-1-k] = hstep.q;
                end
            end else begin : g_hue_hold
                assign n_hrem = src_hrem;
                assign n_hquo = src_hquo;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[k] <= 1'b0;
                end else if (dv_rdy[k]) begin
                    r_dv_v[k] <= src_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (dv_rdy[k]) begin
                    r_dv_mx[k]    <= src_mx;
                    r_dv_dl[k]    <= src_dl;
                    r_dv_srem[k]  <= sstep.rem;
                    r_dv_squo[k]  <= n_squo;
                    r_dv_hnum[k]  <= src_hnum;
                    r_dv_hrem[k]  <= n_hrem;
                    r_dv_hquo[k]  <= n_hquo;
                    r_dv_hbase[k] <= src_hbase;
                    r_dv_hneg[k]  <= src_hneg;
                end
            end
        end
    endgenerate

    // final hue offset, saturation clamp, black and grey
    always_comb begin
        n_sat_wide = WIDE'(r_dv_squo[NDIV-1]);
        if (n_sat_wide > WIDE'(SAT_MAX)) n_sat_wide = WIDE'(SAT_MAX);

        n_out.value_level = r_dv_mx[NDIV-1];
        if (r_dv_mx[NDIV-1] == '0) begin
            n_out.saturation_frac = '0;
        end else begin
            n_out.saturation_frac = n_sat_wide[SAT_W-1:0];
        end

        if (r_dv_dl[NDIV-1] == '0) begin
            n_out.hue_deg = '0;
        end else if (r_dv_hneg[NDIV-1]) begin
            n_out.hue_deg = r_dv_hbase[NDIV-1] - HUE_W'(r_dv_hquo[NDIV-1]);
        end else begin
            n_out.hue_deg = r_dv_hbase[NDIV-1] + HUE_W'(r_dv_hquo[NDIV-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_rdy) begin
            r_out_v <= r_dv_v[NDIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_hsv   = r_out;

    // black item carries no hue and no saturation
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsv.value_level == '0) |->
            (o_hsv.hue_deg == '0 && o_hsv.saturation_frac == '0))
        else $error("black item with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hsv.hue_deg < HUE_FULL))
        else $error("hue out of range");

    // any colored item has delta and max nonzero, so saturation is at least one lsb
    a_hue_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsv.hue_deg != '0) |-> (o_hsv.saturation_frac != '0))
        else $error("nonzero hue with zero saturation");

    // empty input and setup stages never hold off the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_v && !r_pre_v) |-> !o_stall)
        else $error("input stalled while front stages empty");

endmodule

>>> tb/rgb_to_hsv_convert_core_test.sv
// self-checking testbench for the rgb to hsv converter core
`timescale 1ns / 1ps

module rgb_to_hsv_convert_core_test;
    import rgbhsv_pkg::*;

    localparam int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF;
    localparam int CLK_PERIOD    = 12;
    localparam int LATENCY       = SAT_FRAC_BITS + 4;
    localparam int HOLD_CYCLES   = 160;
    localparam int LIMIT_CYCLES  = 200000;

    // shapes of random pixels
    localparam int SHAPE_UNIFORM = 0;
    localparam int SHAPE_TIES    = 1;
    localparam int SHAPE_GREYISH = 2;
    localparam int SHAPE_EDGES   = 3;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   i_stall = 1'b0;
    t_pixel i_pixel = '0;
    logic   o_stall;
    logic   o_valid;
    t_hsv   o_hsv;

    t_hsv expected_hsv[$];
    t_hsv want_hsv;
    int   mismatch_count = 0;
    bit   quiet_mode     = 1'b0;
    bit   hold_req       = 1'b0;

    rgb_to_hsv_convert_core #(
        .SAT_FRAC_BITS(SAT_FRAC_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_pixel(i_pixel),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_hsv  (o_hsv)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("rgb_to_hsv_convert_core test failed");
        $finish;
    end

    // exact integer hsv of one pixel
    function automatic t_hsv predict_hsv(input t_pixel px);
        int unsigned r, g, b, mx, mn, delta, num, hue;
        logic [63:0] sat_wide;
        t_hsv        res;
        r  = px.red_in;
        g  = px.green_in;
        b  = px.blue_in;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta    = mx - mn;
        hue      = 0;
        sat_wide = '0;
        if (mx != 0) begin
            sat_wide = (64'(delta) << SAT_FRAC_BITS) / 64'(mx);
            if (sat_wide > 64'(SAT_MAX)) sat_wide = 64'(SAT_MAX);
        end
        if (delta != 0) begin
            if (mx == r) begin
                if (g >= b) begin
                    hue = (60 * (g - b)) / delta;
                end else begin
                    // floor of 360 - x is 360 - ceil(x)
                    num = 60 * (b - g);
                    hue = 360 - (num + delta - 1) / delta;
                end
            end else if (mx == g) begin
                hue = (120 * delta + 60 * b - 60 * r) / delta;
            end else begin
                hue = (240 * delta + 60 * r - 60 * g) / delta;
            end
        end
        res.hue_deg         = hue[HUE_W-1:0];
        res.saturation_frac = sat_wide[SAT_W-1:0];
        res.value_level     = mx[CHAN_W-1:0];
        return res;
    endfunction

    function automatic bit take_gap();
        return !quiet_mode && ($urandom_range(99) < 23);
    endfunction

    function automatic logic [7:0] edge_level();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            3: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel(input int shape);
        t_pixel     px;
        logic [7:0] lo, hi;
        int         base;
        px = t_pixel'($urandom);
        case (shape)
            SHAPE_TIES: begin
                // red and green each take the top or the bottom level; blue takes the top level or a random one
                lo = 8'($urandom);
                hi = 8'($urandom_range(255, lo));
                px.red_in   = $urandom_range(1) ? hi : lo;
                px.green_in = $urandom_range(1) ? hi : lo;
                px.blue_in  = $urandom_range(2) == 0 ? 8'($urandom) : hi;
            end
            SHAPE_GREYISH: begin
                base        = $urandom_range(255);
                px.red_in   = 8'(base + $urandom_range(2) > 255 ? 255 : base + $urandom_range(2));
                px.green_in = 8'(base >= 2 ? base - $urandom_range(2) : base);
                px.blue_in  = 8'(base);
                if ($urandom_range(1)) px = {px.blue_in, px.red_in, px.green_in};
            end
            SHAPE_EDGES: begin
                px.red_in   = edge_level();
                px.green_in = edge_level();
                px.blue_in  = edge_level();
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_pixel(input t_pixel px);
        while (take_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_hsv.push_back(predict_hsv(px));
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel px;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        send_pixel(px);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_pixel(random_pixel($urandom_range(SHAPE_EDGES)));
        end
    endtask

    // sender goes idle so the last item is not offered again
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (expected_hsv.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hsv.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_hsv);
            end else begin
                want_hsv = expected_hsv.pop_front();
                check_field("hue_deg", want_hsv.hue_deg, o_hsv.hue_deg);
                check_field("saturation_frac", want_hsv.saturation_frac,
                            o_hsv.saturation_frac);
                check_field("value_level", want_hsv.value_level, o_hsv.value_level);
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int k;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (k = 1; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= take_gap();
            end
        end
    end

    task automatic test_named_colors();
        send_rgb(8'd0,   8'd0,   8'd0);     // black
        send_rgb(8'd255, 8'd255, 8'd255);   // white
        send_rgb(8'd128, 8'd128, 8'd128);   // grey
        send_rgb(8'd1,   8'd1,   8'd1);
        send_rgb(8'd255, 8'd0,   8'd0);
        send_rgb(8'd0,   8'd255, 8'd0);
        send_rgb(8'd0,   8'd0,   8'd255);
        send_rgb(8'd255, 8'd255, 8'd0);     // red beats green on a tie
        send_rgb(8'd255, 8'd0,   8'd255);   // red beats blue on a tie
        send_rgb(8'd0,   8'd255, 8'd255);   // green beats blue on a tie
        send_rgb(8'd255, 8'd0,   8'd1);     // just below 360
        send_rgb(8'd255, 8'd1,   8'd0);
        send_rgb(8'd1,   8'd0,   8'd0);     // full saturation with max of one
        send_rgb(8'd0,   8'd1,   8'd0);
        send_rgb(8'd0,   8'd0,   8'd1);
        send_rgb(8'd255, 8'd254, 8'd254);   // lowest nonzero saturation
        send_rgb(8'd254, 8'd255, 8'd253);
        send_rgb(8'd10,  8'd20,  8'd255);
        send_rgb(8'd200, 8'd100, 8'd150);
        send_rgb(8'd100, 8'd200, 8'd50);
    endtask

    task automatic test_random_pixels();
        send_random(500);
    endtask

    task automatic test_steady_stream();
        quiet_mode = 1'b1;
        send_random(250);
        quiet_mode = 1'b0;
    endtask

    task automatic test_output_holdoff();
        hold_req = 1'b1;
        send_random(120);
    endtask

    task automatic test_pause_and_resume();
        send_random(60);
        wait_results_drained();
        send_random(60);
        wait_results_drained();
        send_random(160);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_named_colors();
        test_random_pixels();
        test_steady_stream();
        test_output_holdoff();
        test_pause_and_resume();
        i_valid <= 1'b0;
        wait_results_drained();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("rgb_to_hsv_convert_core test passed");
        end else begin
            $display("rgb_to_hsv_convert_core test failed");
        end
        $finish;
    end

endmodule
